// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL of the power-mode governor.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted (active low).
`define ETPMG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("etpmg assertion failed");

// A condition that must never be seen at a clock edge outside reset.
`define ETPMG_ASSERT_NEVER(lbl, clk, rstn, cond) \
    `ETPMG_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ----- rtl/core/etpmg_pkg.sv -----
// Shared constants and types for the EMA threshold power-mode governor.
// Depends on nothing; imported by etpmg_ema, the top level and the testbench.
`default_nettype none

package etpmg_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int DATA_W   = 16;
    localparam int UTIL_W   = 15;
    localparam int WEIGHT_W = 9;
    localparam int LIMIT_W  = 15;
    localparam int HOLD_W   = 4;
    localparam int CAP_W    = 7;
    localparam int CORES_W  = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 96;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMA_WEIGHT        = 3'd0,
        REG_HOT_TEMP_LIMIT    = 3'd1,
        REG_LOW_UTIL_LIMIT    = 3'd2,
        REG_HIGH_UTIL_LIMIT   = 3'd3,
        REG_BANDWIDTH_CEILING = 3'd4,
        REG_COOLDOWN_STEPS    = 3'd5
    } cfg_index_t;

    localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RST   = 9'd77;
    localparam logic [DATA_W-1:0]   HOT_TEMP_RST     = 16'd21760;
    localparam logic [LIMIT_W-1:0]  LOW_UTIL_RST     = 15'd2560;
    localparam logic [LIMIT_W-1:0]  HIGH_UTIL_RST    = 15'd20480;
    localparam logic [DATA_W-1:0]   BW_CEILING_RST   = 16'd25600;
    localparam logic [HOLD_W-1:0]   COOLDOWN_RST     = 4'd2;

    localparam logic [CAP_W-1:0]   CAP_POWERSAVE   = 7'd50;
    localparam logic [CAP_W-1:0]   CAP_PERFORMANCE = 7'd100;
    localparam logic [CORES_W-1:0] CORES_PERFORMANCE = 3'd4;
    localparam logic [CORES_W-1:0] CORES_NONE        = 3'd0;

    // Action currently in force.
    typedef struct packed {
        logic [CAP_W-1:0]   cap;
        logic               perf;
        logic [CORES_W-1:0] cores;
        logic               migrate;
    } action_t;

    localparam action_t ACTION_RST       = '{cap: CAP_PERFORMANCE, perf: 1'b0,
                                             cores: CORES_NONE, migrate: 1'b0};
    localparam action_t ACTION_POWERSAVE = '{cap: CAP_POWERSAVE, perf: 1'b0,
                                             cores: CORES_NONE, migrate: 1'b1};
    localparam action_t ACTION_PERF      = '{cap: CAP_PERFORMANCE, perf: 1'b1,
                                             cores: CORES_PERFORMANCE, migrate: 1'b0};

endpackage

`default_nettype wire

// ----- rtl/core/ema_threshold_power_mode_governor.sv -----
// EMA threshold power-mode governor.
//
// Usage: one telemetry sample per transfer on the s_ channel (utilization, IPC,
// iowait, disk, memory bandwidth, temperature; utilization is unsigned Q7.8, the
// rest unsigned Q8.8). Every sample produces exactly one result transfer on the
// m_ channel with the five smoothed averages and the power action in force after it.
// Path: an accepted sample sits in the input register and is processed into the
// result register, which drives m_tvalid, once that register is free or being
// taken.
// Throughput: one sample per cycle while m_tready is high. The averages, the hold
// counter and the action update combinationally between the input and result
// registers, so a following sample sees the new state with no bubble.
// Stalls: while m_tready is low the result holds and one more sample may wait
// in the input register; s_tready then drops until the result is taken.
// Reset (aresetn low, synchronous) clears both stages, restores the register
// defaults and returns the averages to zero (IPC to 1.0) with cap 100 and no hold.
// Configuration: cfg_wr_en with cfg_index and cfg_wdata writes one register per
// edge; unknown indexes are ignored. Write only while the block is idle.
`default_nettype none

module ema_threshold_power_mode_governor (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [etpmg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [etpmg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // util_sample[14:0], ipc_sample[30:15], iowait_sample[46:31],
    // disk_sample[62:47], membw_sample[78:63], temp_sample[94:79], zero pad
    input  wire logic [etpmg_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // avg_util[14:0], avg_ipc[30:15], avg_iowait[46:31], avg_disk[62:47],
    // avg_membw[78:63], freq_cap_percent[85:79], governor_performance[86],
    // reserved_big_cores[89:87], migrate_to_efficient[90], policy_updated[91], zero pad
    output logic [etpmg_pkg::M_TDATA_W-1:0]          m_tdata
);
    import etpmg_pkg::*;

    `include "assert_macros.svh"

    // Configuration registers.
    logic [WEIGHT_W-1:0] ema_weight_reg;
    logic [DATA_W-1:0]   hot_temp_reg;
    logic [LIMIT_W-1:0]  low_util_reg;
    logic [LIMIT_W-1:0]  high_util_reg;
    logic [DATA_W-1:0]   bw_ceiling_reg;
    logic [HOLD_W-1:0]   cooldown_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ema_weight_reg <= EMA_WEIGHT_RST;
            hot_temp_reg   <= HOT_TEMP_RST;
            low_util_reg   <= LOW_UTIL_RST;
            high_util_reg  <= HIGH_UTIL_RST;
            bw_ceiling_reg <= BW_CEILING_RST;
            cooldown_reg   <= COOLDOWN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EMA_WEIGHT:        ema_weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                REG_HOT_TEMP_LIMIT:    hot_temp_reg   <= cfg_wdata[DATA_W-1:0];
                REG_LOW_UTIL_LIMIT:    low_util_reg   <= cfg_wdata[LIMIT_W-1:0];
                REG_HIGH_UTIL_LIMIT:   high_util_reg  <= cfg_wdata[LIMIT_W-1:0];
                REG_BANDWIDTH_CEILING: bw_ceiling_reg <= cfg_wdata[DATA_W-1:0];
                REG_COOLDOWN_STEPS:    cooldown_reg   <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register stage.
    logic                 in_valid_reg;
    logic [UTIL_W-1:0]    in_util_reg;
    logic [DATA_W-1:0]    in_ipc_reg;
    logic [DATA_W-1:0]    in_iowait_reg;
    logic [DATA_W-1:0]    in_disk_reg;
    logic [DATA_W-1:0]    in_membw_reg;
    logic [DATA_W-1:0]    in_temp_reg;

    logic out_valid_reg;
    logic advance;
    logic s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_util_reg   <= s_tdata[14:0];
            in_ipc_reg    <= s_tdata[30:15];
            in_iowait_reg <= s_tdata[46:31];
            in_disk_reg   <= s_tdata[62:47];
            in_membw_reg  <= s_tdata[78:63];
            in_temp_reg   <= s_tdata[94:79];
        end
    end

    // Governor state.
    logic [DATA_W-1:0] util_avg_reg,   util_avg_next;
    logic [DATA_W-1:0] ipc_avg_reg,    ipc_avg_next;
    logic [DATA_W-1:0] iowait_avg_reg, iowait_avg_next;
    logic [DATA_W-1:0] disk_avg_reg,   disk_avg_next;
    logic [DATA_W-1:0] membw_avg_reg,  membw_avg_next;
    logic [HOLD_W-1:0] hold_cnt_reg,   hold_cnt_next;
    action_t           action_reg,     action_next;
    logic              updated_next;

    logic [WEIGHT_W-1:0] weight_sat;
    logic [DATA_W-1:0]   membw_clamped;

    assign weight_sat    = (32'(ema_weight_reg) > ONE) ? WEIGHT_W'(ONE) : ema_weight_reg;
    assign membw_clamped = (in_membw_reg > bw_ceiling_reg) ? bw_ceiling_reg : in_membw_reg;

    etpmg_ema u_ema_util (
        .sample  ({1'b0, in_util_reg}),
        .avg_old (util_avg_reg),
        .weight  (weight_sat),
        .avg_new (util_avg_next)
    );

    etpmg_ema u_ema_ipc (
        .sample  (in_ipc_reg),
        .avg_old (ipc_avg_reg),
        .weight  (weight_sat),
        .avg_new (ipc_avg_next)
    );

    etpmg_ema u_ema_iowait (
        .sample  (in_iowait_reg),
        .avg_old (iowait_avg_reg),
        .weight  (weight_sat),
        .avg_new (iowait_avg_next)
    );

    etpmg_ema u_ema_disk (
        .sample  (in_disk_reg),
        .avg_old (disk_avg_reg),
        .weight  (weight_sat),
        .avg_new (disk_avg_next)
    );

    etpmg_ema u_ema_membw (
        .sample  (membw_clamped),
        .avg_old (membw_avg_reg),
        .weight  (weight_sat),
        .avg_new (membw_avg_next)
    );

    // Decision: a running hold wins, then powersave, then performance.
    always_comb begin
        hold_cnt_next = hold_cnt_reg;
        action_next   = action_reg;
        updated_next  = 1'b0;
        if (hold_cnt_reg != '0) begin
            hold_cnt_next = hold_cnt_reg - 1'b1;
        end else if (in_temp_reg > hot_temp_reg
                     || util_avg_next < {1'b0, low_util_reg}) begin
            action_next   = ACTION_POWERSAVE;
            updated_next  = 1'b1;
            hold_cnt_next = cooldown_reg;
        end else if (util_avg_next > {1'b0, high_util_reg}) begin
            action_next   = ACTION_PERF;
            updated_next  = 1'b1;
            hold_cnt_next = cooldown_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            util_avg_reg   <= '0;
            ipc_avg_reg    <= DATA_W'(ONE);
            iowait_avg_reg <= '0;
            disk_avg_reg   <= '0;
            membw_avg_reg  <= '0;
            hold_cnt_reg   <= '0;
            action_reg     <= ACTION_RST;
        end else if (advance) begin
            util_avg_reg   <= util_avg_next;
            ipc_avg_reg    <= ipc_avg_next;
            iowait_avg_reg <= iowait_avg_next;
            disk_avg_reg   <= disk_avg_next;
            membw_avg_reg  <= membw_avg_next;
            hold_cnt_reg   <= hold_cnt_next;
            action_reg     <= action_next;
        end
    end

    // Result register stage.
    logic [UTIL_W-1:0] out_util_reg;
    logic [DATA_W-1:0] out_ipc_reg;
    logic [DATA_W-1:0] out_iowait_reg;
    logic [DATA_W-1:0] out_disk_reg;
    logic [DATA_W-1:0] out_membw_reg;
    action_t           out_action_reg;
    logic              out_updated_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_util_reg    <= util_avg_next[UTIL_W-1:0];
            out_ipc_reg     <= ipc_avg_next;
            out_iowait_reg  <= iowait_avg_next;
            out_disk_reg    <= disk_avg_next;
            out_membw_reg   <= membw_avg_next;
            out_action_reg  <= action_next;
            out_updated_reg <= updated_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_updated_reg, out_action_reg.migrate,
                       out_action_reg.cores, out_action_reg.perf, out_action_reg.cap,
                       out_membw_reg, out_disk_reg, out_iowait_reg, out_ipc_reg,
                       out_util_reg};

    // A sample that arrives during a hold never takes a decision.
    `ETPMG_ASSERT(a_hold_blocks_update, aclk, aresetn,
        advance && hold_cnt_reg != '0 |=> !out_updated_reg)
    // A decision reloads the hold counter from the cooldown register.
    `ETPMG_ASSERT(a_decision_reloads_hold, aclk, aresetn,
        advance && updated_next |=> hold_cnt_reg == $past(cooldown_reg))
    // Performance and migration to efficiency cores never go together.
    `ETPMG_ASSERT_NEVER(a_action_consistent, aclk, aresetn,
        action_reg.perf && action_reg.migrate)

endmodule

`default_nettype wire

// ----- rtl/core/etpmg_ema.sv -----
// One exponential moving average update: old + (w * (x - old)) >> FRAC_BITS.
// This equals (w*x + (ONE-w)*old) >> FRAC_BITS with rounding down. Uses etpmg_pkg.
`default_nettype none

module etpmg_ema (
    input  wire logic [etpmg_pkg::DATA_W-1:0]   sample,
    input  wire logic [etpmg_pkg::DATA_W-1:0]   avg_old,
    input  wire logic [etpmg_pkg::WEIGHT_W-1:0] weight,
    output logic      [etpmg_pkg::DATA_W-1:0]   avg_new
);
    import etpmg_pkg::*;

    localparam int DIFF_W = DATA_W + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_W + 1;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [WEIGHT_W:0]   weight_s;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   step;

    assign diff     = $signed({1'b0, sample}) - $signed({1'b0, avg_old});
    assign weight_s = $signed({1'b0, weight});
    assign prod     = PROD_W'(diff) * PROD_W'(weight_s);
    // The arithmetic shift floors negative steps, matching the unsigned form.
    assign step     = prod >>> FRAC_BITS;
    // The new average lies between old and sample, so 16 bits always hold it.
    assign avg_new  = avg_old + step[DATA_W-1:0];

endmodule

`default_nettype wire

// ----- sim/ema_threshold_power_mode_governor_tb.sv -----
// Self-checking testbench for the EMA threshold power-mode governor.
// Drives telemetry samples, predicts every result transfer and compares it field by field.
// Depends on etpmg_pkg and the ema_threshold_power_mode_governor RTL.
module ema_threshold_power_mode_governor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import etpmg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = 3'd7;
    localparam int LONG_HOLD_OFF = 64;

    // Field order matches s_tdata from the top bit down.
    typedef struct packed {
        logic              pad;
        logic [DATA_W-1:0] temp_sample;
        logic [DATA_W-1:0] membw_sample;
        logic [DATA_W-1:0] disk_sample;
        logic [DATA_W-1:0] iowait_sample;
        logic [DATA_W-1:0] ipc_sample;
        logic [UTIL_W-1:0] util_sample;
    } telemetry_t;

    typedef struct packed {
        logic [3:0]         pad;
        logic               policy_updated;
        logic               migrate_to_efficient;
        logic [CORES_W-1:0] reserved_big_cores;
        logic               governor_performance;
        logic [CAP_W-1:0]   freq_cap_percent;
        logic [DATA_W-1:0]  avg_membw;
        logic [DATA_W-1:0]  avg_disk;
        logic [DATA_W-1:0]  avg_iowait;
        logic [DATA_W-1:0]  avg_ipc;
        logic [UTIL_W-1:0]  avg_util;
    } governor_out_t;

    // Order: weight, hot limit, low limit, high limit, bandwidth ceiling, cooldown.
    typedef struct {
        int unsigned weight;
        int unsigned hot;
        int unsigned low;
        int unsigned high;
        int unsigned ceiling;
        int unsigned cooldown;
    } governor_settings_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    ema_threshold_power_mode_governor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the registers and the governor state.
    logic [WEIGHT_W-1:0] cfg_weight;
    logic [DATA_W-1:0]   cfg_hot_temp;
    logic [LIMIT_W-1:0]  cfg_low_util;
    logic [LIMIT_W-1:0]  cfg_high_util;
    logic [DATA_W-1:0]   cfg_bw_ceiling;
    logic [HOLD_W-1:0]   cfg_cooldown;

    logic [DATA_W-1:0] util_avg, ipc_avg, iowait_avg, disk_avg, membw_avg;
    logic [HOLD_W-1:0] hold_left;
    action_t           action_now;

    telemetry_t    sample_queue[$];
    governor_out_t expected_results[$];

    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned stall_requests    = 0;
    int unsigned stalls_served     = 0;
    int unsigned hold_off_left     = 0;

    int n_errors = 0;
    int n_samples = 0;
    int n_results = 0;
    int n_settings = 1;
    int n_powersave = 0;
    int n_perf = 0;
    int n_held = 0;
    int n_quiet = 0;

    function automatic void reset_predictor();
        cfg_weight     = EMA_WEIGHT_RST;
        cfg_hot_temp   = HOT_TEMP_RST;
        cfg_low_util   = LOW_UTIL_RST;
        cfg_high_util  = HIGH_UTIL_RST;
        cfg_bw_ceiling = BW_CEILING_RST;
        cfg_cooldown   = COOLDOWN_RST;
        util_avg   = '0;
        ipc_avg    = DATA_W'(ONE);
        iowait_avg = '0;
        disk_avg   = '0;
        membw_avg  = '0;
        hold_left  = '0;
        action_now = ACTION_RST;
    endfunction

    function automatic logic [DATA_W-1:0] ema_update(logic [DATA_W-1:0] sample,
                                                     logic [DATA_W-1:0] prev,
                                                     int unsigned w);
        int unsigned acc;
        acc = w * sample + (ONE - w) * prev;
        return DATA_W'(acc >> FRAC_BITS);
    endfunction

    function automatic governor_out_t predict_governor(telemetry_t s);
        governor_out_t r;
        int unsigned   w;
        logic [DATA_W-1:0] membw;
        r = '0;
        w = (cfg_weight > ONE) ? ONE : cfg_weight;
        membw = (s.membw_sample > cfg_bw_ceiling) ? cfg_bw_ceiling : s.membw_sample;
        util_avg   = ema_update({1'b0, s.util_sample}, util_avg, w);
        ipc_avg    = ema_update(s.ipc_sample, ipc_avg, w);
        iowait_avg = ema_update(s.iowait_sample, iowait_avg, w);
        disk_avg   = ema_update(s.disk_sample, disk_avg, w);
        membw_avg  = ema_update(membw, membw_avg, w);

        if (hold_left != 0) begin
            hold_left = hold_left - 1'b1;
            n_held++;
        end else if (s.temp_sample > cfg_hot_temp || util_avg < cfg_low_util) begin
            action_now = ACTION_POWERSAVE;
            r.policy_updated = 1'b1;
            n_powersave++;
        end else if (util_avg > cfg_high_util) begin
            action_now = ACTION_PERF;
            r.policy_updated = 1'b1;
            n_perf++;
        end else begin
            n_quiet++;
        end
        if (r.policy_updated)
            hold_left = cfg_cooldown;

        r.avg_util             = util_avg[UTIL_W-1:0];
        r.avg_ipc              = ipc_avg;
        r.avg_iowait           = iowait_avg;
        r.avg_disk             = disk_avg;
        r.avg_membw            = membw_avg;
        r.freq_cap_percent     = action_now.cap;
        r.governor_performance = action_now.perf;
        r.reserved_big_cores   = action_now.cores;
        r.migrate_to_efficient = action_now.migrate;
        return r;
    endfunction

    function automatic telemetry_t make_sample(int unsigned util, int unsigned ipc,
                                               int unsigned iowait, int unsigned disk,
                                               int unsigned membw, int unsigned temp);
        telemetry_t s;
        s.pad           = 1'b0;
        s.util_sample   = util[UTIL_W-1:0];
        s.ipc_sample    = ipc[DATA_W-1:0];
        s.iowait_sample = iowait[DATA_W-1:0];
        s.disk_sample   = disk[DATA_W-1:0];
        s.membw_sample  = membw[DATA_W-1:0];
        s.temp_sample   = temp[DATA_W-1:0];
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Sender: a new sample may go out once the current transfer has completed.
    always @(posedge aclk) begin : sample_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_governor(telemetry_t'(s_tdata)));
                n_samples++;
            end
            if (!s_tvalid || s_tready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_tdata  <= sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        governor_out_t got;
        governor_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = governor_out_t'(m_tdata);
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("Result transfer with no sample outstanding");
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("avg_util", want.avg_util, got.avg_util);
                    compare_field("avg_ipc", want.avg_ipc, got.avg_ipc);
                    compare_field("avg_iowait", want.avg_iowait, got.avg_iowait);
                    compare_field("avg_disk", want.avg_disk, got.avg_disk);
                    compare_field("avg_membw", want.avg_membw, got.avg_membw);
                    compare_field("freq_cap_percent", want.freq_cap_percent,
                                  got.freq_cap_percent);
                    compare_field("governor_performance", want.governor_performance,
                                  got.governor_performance);
                    compare_field("reserved_big_cores", want.reserved_big_cores,
                                  got.reserved_big_cores);
                    compare_field("migrate_to_efficient", want.migrate_to_efficient,
                                  got.migrate_to_efficient);
                    compare_field("policy_updated", want.policy_updated,
                                  got.policy_updated);
                end
            end
            if (stalls_served != stall_requests) begin
                stalls_served = stall_requests;
                hold_off_left = LONG_HOLD_OFF;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Checked on the falling edge so that all queue updates of the rising edge are seen.
    task automatic wait_until_drained();
        do @(negedge aclk);
        while (sample_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_EMA_WEIGHT:        cfg_weight     = value[WEIGHT_W-1:0];
            REG_HOT_TEMP_LIMIT:    cfg_hot_temp   = value[DATA_W-1:0];
            REG_LOW_UTIL_LIMIT:    cfg_low_util   = value[LIMIT_W-1:0];
            REG_HIGH_UTIL_LIMIT:   cfg_high_util  = value[LIMIT_W-1:0];
            REG_BANDWIDTH_CEILING: cfg_bw_ceiling = value[DATA_W-1:0];
            REG_COOLDOWN_STEPS:    cfg_cooldown   = value[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(governor_settings_t g);
        write_reg(REG_EMA_WEIGHT, g.weight);
        write_reg(REG_HOT_TEMP_LIMIT, g.hot);
        write_reg(REG_LOW_UTIL_LIMIT, g.low);
        write_reg(REG_HIGH_UTIL_LIMIT, g.high);
        write_reg(REG_BANDWIDTH_CEILING, g.ceiling);
        write_reg(REG_COOLDOWN_STEPS, g.cooldown);
        n_settings++;
    endtask

    function automatic governor_settings_t random_settings(int unsigned limit_max);
        governor_settings_t g;
        g.weight   = $urandom_range(300);
        g.hot      = $urandom_range(65535);
        g.low      = $urandom_range(limit_max);
        g.high     = $urandom_range(limit_max);
        g.ceiling  = $urandom_range(65535);
        g.cooldown = $urandom_range(15);
        return g;
    endfunction

    // Utilization comes in bursts around a level so that the smoothed value
    // actually crosses the limits; the other fields are random.
    task automatic queue_random_items(int n_items);
        telemetry_t s;
        int level;
        int run_left;
        int util;
        level = 0;
        run_left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(25, 3);
                case ($urandom_range(6))
                    0:       level = $urandom_range(1500);
                    1:       level = $urandom_range(25600, 20000);
                    2:       level = $urandom_range(25600);
                    3:       level = $urandom_range(32767, 25601);
                    4:       level = int'(cfg_low_util) + int'($urandom_range(1536)) - 768;
                    5:       level = int'(cfg_high_util) + int'($urandom_range(1536)) - 768;
                    default: level = -1;
                endcase
            end
            run_left--;
            if (level < 0)
                util = $urandom_range(32767);
            else
                util = level + int'($urandom_range(512)) - 256;
            if (util < 0)
                util = 0;
            if (util > 32767)
                util = 32767;
            s = make_sample(util, rand_word(), rand_word(), rand_word(), rand_word(), 0);
            case ($urandom_range(7))
                0:       s.temp_sample = rand_word();
                1:       s.temp_sample = cfg_hot_temp;
                2:       s.temp_sample = cfg_hot_temp + 1'b1;
                default: s.temp_sample = DATA_W'($urandom_range(cfg_hot_temp));
            endcase
            sample_queue.push_back(s);
        end
    endtask

    task automatic run_phase(governor_settings_t g, int n_items, int unsigned send_pct,
                             int unsigned recv_pct, bit long_hold_off);
        wait_until_drained();
        apply_settings(g);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        if (long_hold_off)
            stall_requests++;
        queue_random_items(n_items);
    endtask

    initial begin : stimulus
        governor_settings_t g;
        reset_predictor();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        sender_idle_pct   = 11;
        receiver_idle_pct = 52;

        // Reset settings: field extremes, bandwidth clamp, temperature at and over the limit.
        sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 0));
        sample_queue.push_back(make_sample(32767, 65535, 65535, 65535, 65535, 65535));
        sample_queue.push_back(make_sample(32767, 0, 65535, 0, 65535, 0));
        sample_queue.push_back(make_sample(32767, 65535, 0, 65535, 25601, 0));
        sample_queue.push_back(make_sample(25600, 256, 100, 200, 25600, 100));
        sample_queue.push_back(make_sample(25600, 512, 300, 400, 30000, 200));
        sample_queue.push_back(make_sample(25600, 1000, 0, 0, 1, 21760));
        sample_queue.push_back(make_sample(25600, 0, 0, 0, 0, 21761));
        sample_queue.push_back(make_sample(25600, 0, 0, 0, 0, 21761));
        sample_queue.push_back(make_sample(25600, 0, 0, 0, 0, 21761));

        // Oversized weight saturates, zero cooldown leaves no hold between decisions, and
        // writes to unused indexes must change nothing.
        wait_until_drained();
        write_reg(REG_EMA_WEIGHT, 511);
        write_reg(REG_COOLDOWN_STEPS, 0);
        write_reg(REG_BANDWIDTH_CEILING, 0);
        write_reg(REG_HOT_TEMP_LIMIT, 65535);
        write_reg(REG_LOW_UTIL_LIMIT, 0);
        write_reg(REG_HIGH_UTIL_LIMIT, 0);
        write_reg(SPARE_INDEX_LO, 65535);
        write_reg(SPARE_INDEX_HI, 65535);
        n_settings++;
        sample_queue.push_back(make_sample(32767, 65535, 65535, 65535, 65535, 65535));
        sample_queue.push_back(make_sample(12345, 4321, 999, 7, 65535, 0));
        sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 65535));
        sample_queue.push_back(make_sample(0, 65535, 0, 65535, 0, 0));

        // Zero weight freezes the averages; utilization limits at their maximum.
        wait_until_drained();
        write_reg(REG_EMA_WEIGHT, 0);
        write_reg(REG_COOLDOWN_STEPS, 15);
        write_reg(REG_BANDWIDTH_CEILING, 65535);
        write_reg(REG_HOT_TEMP_LIMIT, 0);
        write_reg(REG_LOW_UTIL_LIMIT, 32767);
        write_reg(REG_HIGH_UTIL_LIMIT, 32767);
        n_settings++;
        sample_queue.push_back(make_sample(32767, 65535, 65535, 65535, 65535, 0));
        sample_queue.push_back(make_sample(100, 1, 2, 3, 4, 1));
        sample_queue.push_back(make_sample(25600, 0, 0, 0, 0, 65535));
        sample_queue.push_back(make_sample(0, 0, 0, 0, 0, 0));

        g = '{77, 21760, 2560, 20480, 25600, 2};
        run_phase(g, 180, 11, 52, 1'b1);
        g = '{256, 30000, 5000, 15000, 65535, 0};
        run_phase(g, 180, 11, 52, 1'b0);
        g = '{1, 65535, 0, 0, 1, 15};
        run_phase(g, 180, 11, 52, 1'b0);
        run_phase(random_settings(25600), 180, 52, 11, 1'b1);
        g = '{128, 20000, 25600, 25600, 32768, 1};
        run_phase(g, 180, 52, 11, 1'b0);
        run_phase(random_settings(25600), 180, 52, 11, 1'b0);
        run_phase(random_settings(32767), 180, 0, 0, 1'b1);
        g = '{300, 21760, 2560, 20480, 25600, 3};
        run_phase(g, 180, 0, 0, 1'b0);

        wait_until_drained();
        repeat (6) @(posedge aclk);
        $display("Covered %0d samples and %0d results under %0d register settings.",
                 n_samples, n_results, n_settings);
        $display("Decisions: %0d powersave, %0d performance; %0d held, %0d below all limits.",
                 n_powersave, n_perf, n_held, n_quiet);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout: %0d samples still queued, %0d results outstanding.",
                 sample_queue.size(), expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/etpmg_pkg.sv
rtl/core/etpmg_ema.sv
rtl/core/ema_threshold_power_mode_governor.sv
sim/ema_threshold_power_mode_governor_tb.sv
